@@ sv/trs_transform_matrix_builder_unit_assert.svh @@
// Assertion macros for the transform matrix builder.
`ifndef TRS_TRANSFORM_MATRIX_BUILDER_UNIT_ASSERT_SVH
`define TRS_TRANSFORM_MATRIX_BUILDER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define TRS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define TRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define TRS_ASSERT_SAME(lbl, ante, cons)
`define TRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/trs_pkg.sv @@
// Shared types, constants and arithmetic helpers of the transform matrix builder.
package trs_pkg;
    localparam int AngW   = 16;
    localparam int CordW  = 20;
    localparam int TrigW  = 18;
    localparam int ProdW  = 36;
    localparam int SumW   = 52;
    localparam int EntW   = 20;
    localparam int OutW   = 16;
    localparam int PosW   = 32;
    localparam int Steps  = 16;
    localparam int Lanes  = 3;
    localparam int Ents   = 9;

    localparam logic signed [CordW-1:0] QPi     = 20'sd205887;
    localparam logic signed [CordW-1:0] QTwoPi  = 20'sd411775;
    localparam logic signed [CordW-1:0] QHalfPi = 20'sd102944;
    localparam logic signed [CordW-1:0] QGain   = 20'sd39797;
    localparam logic signed [CordW-1:0] QOne    = 20'sd65536;
    localparam logic signed [OutW-1:0]  OutMax  = 16'sh7fff;
    localparam logic signed [OutW-1:0]  OutMin  = 16'sh8000;

    typedef struct packed {
        logic signed [CordW-1:0] x;
        logic signed [CordW-1:0] y;
        logic signed [CordW-1:0] z;
        logic                    flip;
    } lane_t;

    typedef struct packed {
        logic signed [AngW-1:0] scale_x;
        logic signed [AngW-1:0] scale_y;
        logic signed [AngW-1:0] scale_z;
        logic signed [PosW-1:0] pos_x;
        logic signed [PosW-1:0] pos_y;
        logic signed [PosW-1:0] pos_z;
    } side_t;

    function automatic logic signed [CordW-1:0] atan_step(input int i);
        logic signed [CordW-1:0] a;
        case (i)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

    function automatic lane_t reduce_angle(input logic signed [AngW-1:0] ang);
        lane_t l;
        logic signed [CordW-1:0] z;
        z = {ang, 4'b0000};
        if (z > QPi) z = z - QTwoPi;
        if (z < -QPi) z = z + QTwoPi;
        l.flip = 1'b0;
        if (z > QHalfPi) begin
            z = QPi - z;
            l.flip = 1'b1;
        end else if (z < -QHalfPi) begin
            z = -QPi - z;
            l.flip = 1'b1;
        end
        l.x = QGain;
        l.y = '0;
        l.z = z;
        return l;
    endfunction

    function automatic logic signed [TrigW-1:0] clamp_trig(input logic signed [CordW-1:0] v);
        logic signed [TrigW-1:0] r;
        if (v > QOne) r = QOne[TrigW-1:0];
        else if (v < -QOne) r = 18'sh30000;
        else r = v[TrigW-1:0];
        return r;
    endfunction

    function automatic logic signed [OutW-1:0] sat_out(input logic signed [EntW-1:0] v);
        logic signed [OutW-1:0] r;
        if (v > EntW'(OutMax)) r = OutMax;
        else if (v < EntW'(OutMin)) r = OutMin;
        else r = v[OutW-1:0];
        return r;
    endfunction
endpackage

@@ sv/trs_transform_matrix_builder_unit.sv @@
// Top level of the scale, rotation and translation matrix builder.
//
//  Channel | Handshake            | Fields
//  in      | in_valid / in_ready  | scale_x..z, angle_about_z/y/x, pos_x..z
//  out     | out_valid / out_ready| m00..m22, t_x..t_z
//
// A new beat may enter in any cycle with out_ready high or no output beat held;
// each beat passes 16 CORDIC cells, two product stages and the output register.
// Reset clears all stage valid bits; data registers are not reset.
// When the output beat is held by out_ready low, the whole pipeline freezes.
module trs_transform_matrix_builder_unit
    import trs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [AngW-1:0] scale_x,
    input  logic signed [AngW-1:0] scale_y,
    input  logic signed [AngW-1:0] scale_z,
    input  logic signed [AngW-1:0] angle_about_z,
    input  logic signed [AngW-1:0] angle_about_y,
    input  logic signed [AngW-1:0] angle_about_x,
    input  logic signed [PosW-1:0] pos_x,
    input  logic signed [PosW-1:0] pos_y,
    input  logic signed [PosW-1:0] pos_z,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [OutW-1:0] m00,
    output logic signed [OutW-1:0] m01,
    output logic signed [OutW-1:0] m02,
    output logic signed [OutW-1:0] m10,
    output logic signed [OutW-1:0] m11,
    output logic signed [OutW-1:0] m12,
    output logic signed [OutW-1:0] m20,
    output logic signed [OutW-1:0] m21,
    output logic signed [OutW-1:0] m22,
    output logic signed [PosW-1:0] t_x,
    output logic signed [PosW-1:0] t_y,
    output logic signed [PosW-1:0] t_z
);
`include "trs_transform_matrix_builder_unit_assert.svh"

    logic                            advance;
    logic                            chain_valid [Steps+1];
    lane_t [Lanes-1:0]               chain_lane  [Steps+1];
    side_t                           chain_side  [Steps+1];
    logic signed [Ents-1:0][OutW-1:0] mat;
    side_t                           out_side;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    assign chain_valid[0]   = in_valid;
    assign chain_lane[0][0] = reduce_angle(angle_about_z);
    assign chain_lane[0][1] = reduce_angle(angle_about_y);
    assign chain_lane[0][2] = reduce_angle(angle_about_x);
    assign chain_side[0]    = '{scale_x: scale_x, scale_y: scale_y, scale_z: scale_z,
                                pos_x: pos_x, pos_y: pos_y, pos_z: pos_z};

    for (genvar g = 0; g < Steps; g++) begin : g_cell
        trs_cordic_cell #(.Step(g)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (chain_valid[g]),
            .in_lane   (chain_lane[g]),
            .in_side   (chain_side[g]),
            .out_valid (chain_valid[g+1]),
            .out_lane  (chain_lane[g+1]),
            .out_side  (chain_side[g+1])
        );
    end

    trs_matrix_unit u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (chain_valid[Steps]),
        .in_lane   (chain_lane[Steps]),
        .in_side   (chain_side[Steps]),
        .out_valid (out_valid),
        .out_m     (mat),
        .out_side  (out_side)
    );

    assign m00 = mat[0];
    assign m01 = mat[1];
    assign m02 = mat[2];
    assign m10 = mat[3];
    assign m11 = mat[4];
    assign m12 = mat[5];
    assign m20 = mat[6];
    assign m21 = mat[7];
    assign m22 = mat[8];
    assign t_x = out_side.pos_x;
    assign t_y = out_side.pos_y;
    assign t_z = out_side.pos_z;

    `TRS_ASSERT_SAME(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready))
    `TRS_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, chain_valid[1])
    `TRS_ASSERT_NEXT(a_stall_holds_chain, !advance, $stable(chain_valid[1]) && $stable(out_valid))
endmodule

@@ sv/trs_cordic_cell.sv @@
// One CORDIC iteration applied to all three angle lanes, with the side payload alongside.
module trs_cordic_cell
    import trs_pkg::*;
#(
    parameter int Step = 0
)(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  lane_t [Lanes-1:0]   in_lane,
    input  side_t               in_side,
    output logic                out_valid,
    output lane_t [Lanes-1:0]   out_lane,
    output side_t               out_side
);
    logic              valid_reg;
    lane_t [Lanes-1:0] lane_reg, lane_next;
    side_t             side_reg;

    always_comb
    begin
        for (int k = 0; k < Lanes; k++) begin
            lane_next[k].flip = in_lane[k].flip;
            if (!in_lane[k].z[CordW-1]) begin
                lane_next[k].x = in_lane[k].x - (in_lane[k].y >>> Step);
                lane_next[k].y = in_lane[k].y + (in_lane[k].x >>> Step);
                lane_next[k].z = in_lane[k].z - atan_step(Step);
            end else begin
                lane_next[k].x = in_lane[k].x + (in_lane[k].y >>> Step);
                lane_next[k].y = in_lane[k].y - (in_lane[k].x >>> Step);
                lane_next[k].z = in_lane[k].z + atan_step(Step);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (en) valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            lane_reg <= lane_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;
    assign out_side  = side_reg;
endmodule

@@ sv/trs_matrix_unit.sv @@
// Product, rounding and scaling stages that turn sines and cosines into matrix entries.
module trs_matrix_unit
    import trs_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  lane_t [Lanes-1:0]            in_lane,
    input  side_t                        in_side,
    output logic                         out_valid,
    output logic signed [Ents-1:0][OutW-1:0] out_m,
    output side_t                        out_side
);
    logic signed [TrigW-1:0] ca, sa, cb, sb, cc, sc;
    logic signed [ProdW-1:0] ca_sb_reg, sa_sb_reg, ca_cb_reg, sa_cb_reg, cb_sc_reg, cb_cc_reg;
    logic signed [ProdW-1:0] sa_cc_reg, sa_sc_reg, ca_cc_reg, ca_sc_reg;
    logic signed [TrigW-1:0] sb_reg, sc_reg, cc_reg;
    logic                    v1_reg, v2_reg, v3_reg;
    side_t                   s1_reg, s2_reg, s3_reg;
    logic signed [EntW-1:0]  r_next [Ents];
    logic signed [EntW-1:0]  r_reg  [Ents];
    logic signed [SumW-1:0]  acc [4];
    logic signed [ProdW-1:0] two [4];
    logic signed [ProdW-1:0] q [Ents];
    logic signed [Ents-1:0][OutW-1:0] m_next, m_reg;
    logic signed [AngW-1:0]  col_scale [Ents];

    always_comb
    begin
        ca = clamp_trig(in_lane[0].flip ? -in_lane[0].x : in_lane[0].x);
        sa = clamp_trig(in_lane[0].y);
        cb = clamp_trig(in_lane[1].flip ? -in_lane[1].x : in_lane[1].x);
        sb = clamp_trig(in_lane[1].y);
        cc = clamp_trig(in_lane[2].flip ? -in_lane[2].x : in_lane[2].x);
        sc = clamp_trig(in_lane[2].y);
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            ca_sb_reg <= ProdW'(ca * sb);
            sa_sb_reg <= ProdW'(sa * sb);
            ca_cb_reg <= ProdW'(ca * cb);
            sa_cb_reg <= ProdW'(sa * cb);
            cb_sc_reg <= ProdW'(cb * sc);
            cb_cc_reg <= ProdW'(cb * cc);
            sa_cc_reg <= ProdW'(sa * cc);
            sa_sc_reg <= ProdW'(sa * sc);
            ca_cc_reg <= ProdW'(ca * cc);
            ca_sc_reg <= ProdW'(ca * sc);
            sb_reg    <= sb;
            sc_reg    <= sc;
            cc_reg    <= cc;
            s1_reg    <= in_side;
        end
    end

    always_comb
    begin
        acc[0] = SumW'(ca_sb_reg * sc_reg) - (SumW'(sa_cc_reg) <<< 16) + SumW'(64'sd2147483648);
        acc[1] = SumW'(ca_sb_reg * cc_reg) + (SumW'(sa_sc_reg) <<< 16) + SumW'(64'sd2147483648);
        acc[2] = SumW'(sa_sb_reg * sc_reg) + (SumW'(ca_cc_reg) <<< 16) + SumW'(64'sd2147483648);
        acc[3] = SumW'(sa_sb_reg * cc_reg) - (SumW'(ca_sc_reg) <<< 16) + SumW'(64'sd2147483648);
        two[0] = ca_cb_reg + ProdW'(32768);
        two[1] = sa_cb_reg + ProdW'(32768);
        two[2] = cb_sc_reg + ProdW'(32768);
        two[3] = cb_cc_reg + ProdW'(32768);
        r_next[0] = two[0][ProdW-1:16];
        r_next[1] = acc[0][SumW-1:32];
        r_next[2] = acc[1][SumW-1:32];
        r_next[3] = two[1][ProdW-1:16];
        r_next[4] = acc[2][SumW-1:32];
        r_next[5] = acc[3][SumW-1:32];
        r_next[6] = -EntW'(sb_reg);
        r_next[7] = two[2][ProdW-1:16];
        r_next[8] = two[3][ProdW-1:16];
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            r_reg  <= r_next;
            s2_reg <= s1_reg;
        end
    end

    always_comb
    begin
        for (int e = 0; e < Ents; e++) begin
            case (e % 3)
                0:       col_scale[e] = s2_reg.scale_x;
                1:       col_scale[e] = s2_reg.scale_y;
                default: col_scale[e] = s2_reg.scale_z;
            endcase
            q[e] = ProdW'(r_reg[e] * col_scale[e]) + ProdW'(32768);
            m_next[e] = sat_out(q[e][ProdW-1:16]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            m_reg  <= m_next;
            s3_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_m     = m_reg;
    assign out_side  = s3_reg;
endmodule
